@@ src/sha1_message_digest_core_assert.svh @@
// assertion macros shared by the checker
`ifndef SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH

// expression must never hold outside reset
`define SHA1MD_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("sha1md check failed");

// same-cycle implication
`define SHA1MD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sha1md check failed");

// next-cycle implication
`define SHA1MD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sha1md check failed");

`endif

@@ src/sha1md_pkg.sv @@
package sha1md_pkg;

  localparam int unsigned NumChain = 5;
  localparam int unsigned NumSched = 16;
  localparam int unsigned NumRounds = 80;

  typedef logic [31:0] word_t;
  typedef logic [NumChain-1:0][31:0] chain_t;
  typedef logic [NumSched-1:0][31:0] sched_t;
  typedef logic [6:0] round_idx_t;

  localparam chain_t HInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;
  localparam round_idx_t LastRound = 7'(NumRounds - 1);
  localparam logic [2:0] LastWord = 3'(NumChain - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  // what the sequencer tells the round unit
  typedef struct packed {
    round_idx_t rnd;
  } round_ctrl_t;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

@@ src/sha1md_in_if.sv @@
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       final_item;

  modport source (output valid, output data_byte, output byte_present,
                  output final_item, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input final_item, output ready);
endinterface

@@ src/sha1md_out_if.sv @@
interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        digest_done;

  modport source (output valid, output digest_word, output word_number,
                  output digest_done, input ready);
  modport sink (input valid, input digest_word, input word_number,
                input digest_done, output ready);
endinterface

@@ src/sha1md_round.sv @@
module sha1md_round (
  input  sha1md_pkg::round_ctrl_t ctrl_i,
  input  sha1md_pkg::chain_t      vars_i,
  input  sha1md_pkg::word_t       w_i,
  output sha1md_pkg::chain_t      vars_o
);
  import sha1md_pkg::*;

  word_t a, b, c, d, e;
  word_t f, k, tmp;

  assign a = vars_i[0];
  assign b = vars_i[1];
  assign c = vars_i[2];
  assign d = vars_i[3];
  assign e = vars_i[4];

  always_comb begin
    if (ctrl_i.rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctrl_i.rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctrl_i.rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp = rotl(a, 5) + f + e + k + w_i;

  assign vars_o = {d, c, rotl(b, 30), a, tmp};

endmodule

@@ src/sha1_message_digest_core.sv @@
// SHA-1 digest core. Message bytes come in one beat each on in_i; a beat with
// final_item set ends the message (with byte_present low it carries no byte,
// which digests an empty message). Every 64th byte starts a compression
// during which in_i is not ready: 80 rounds through the single round unit,
// one round per cycle, then a fold of the working words into the chaining
// words. After the final beat the core generates the 0x80 marker, zero fill
// and the 64-bit length one byte per cycle outside compressions (9 to 72
// bytes, one or two compressions), then presents the digest as five beats on
// out_o, H0 first, with digest_done on the fifth. The next message may start
// once the fifth beat is taken.
module sha1_message_digest_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  sha1md_in_if.sink         in_i,
  sha1md_out_if.source      out_o
);
  import sha1md_pkg::*;

  state_e     state_q, state_d;
  chain_t     chain_q, chain_d;
  chain_t     vars_q, vars_d, vars_next;
  sched_t     sched_q, sched_d;
  logic [23:0] acc_q, acc_d;
  logic [5:0] fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  round_idx_t rnd_q, rnd_d;
  logic       pad_q, pad_d;
  logic       mark_q, mark_d;
  logic       lenp_q, lenp_d;
  logic [2:0] wcnt_q, wcnt_d;

  logic       push_en;
  logic [7:0] push_byte;
  logic       block_full;
  logic       len_now;
  word_t      w_expand;
  round_ctrl_t rctrl;

  assign rctrl.rnd = rnd_q;
  assign w_expand = rotl(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0], 1);

  sha1md_round u_round (
    .ctrl_i (rctrl),
    .vars_i (vars_q),
    .w_i    (sched_q[0]),
    .vars_o (vars_next)
  );

  assign block_full = push_en && (fill_q == 6'd63);
  assign len_now = mark_q && (lenp_q || (fill_q == LenPos));

  always_comb begin
    state_d = state_q;
    chain_d = chain_q;
    vars_d = vars_q;
    sched_d = sched_q;
    acc_d = acc_q;
    fill_d = fill_q;
    bits_d = bits_q;
    rnd_d = rnd_q;
    pad_d = pad_q;
    mark_d = mark_q;
    lenp_d = lenp_q;
    wcnt_d = wcnt_q;
    push_en = 1'b0;
    push_byte = 8'h00;
    in_i.ready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          push_en = in_i.byte_present;
          push_byte = in_i.data_byte;
          if (in_i.byte_present) begin
            bits_d = bits_q + 64'd8;
          end
          if (in_i.final_item) begin
            pad_d = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        mark_d = 1'b1;
        if (!mark_q) begin
          push_byte = PadMarker;
        end else if (len_now) begin
          // length goes out msb first
          push_byte = bits_q[63:56];
          bits_d = {bits_q[55:0], 8'h00};
          lenp_d = 1'b1;
        end
      end
      ST_ROUND: begin
        vars_d = vars_next;
        sched_d = {w_expand, sched_q[NumSched-1:1]};
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == LastRound) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < NumChain; i++) begin
          chain_d[i] = chain_q[i] + vars_q[i];
        end
        if (lenp_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          // shift the digest out and refill with the initial values
          chain_d = {HInit[wcnt_q], chain_q[NumChain-1:1]};
          wcnt_d = wcnt_q + 3'd1;
          if (wcnt_q == LastWord) begin
            wcnt_d = 3'd0;
            pad_d = 1'b0;
            mark_d = 1'b0;
            lenp_d = 1'b0;
            bits_d = 64'd0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (push_en) begin
      acc_d = {acc_q[15:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q[1:0] == 2'd3) begin
        sched_d = {{acc_q, push_byte}, sched_q[NumSched-1:1]};
      end
    end
    if (block_full) begin
      vars_d = chain_q;
      rnd_d = '0;
      state_d = ST_ROUND;
    end
  end

  assign out_o.valid = (state_q == ST_OUT);
  assign out_o.digest_word = chain_q[0];
  assign out_o.word_number = wcnt_q;
  assign out_o.digest_done = (wcnt_q == LastWord);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= HInit;
      fill_q <= '0;
      bits_q <= '0;
      rnd_q <= '0;
      pad_q <= 1'b0;
      mark_q <= 1'b0;
      lenp_q <= 1'b0;
      wcnt_q <= '0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      fill_q <= fill_d;
      bits_q <= bits_d;
      rnd_q <= rnd_d;
      pad_q <= pad_d;
      mark_q <= mark_d;
      lenp_q <= lenp_d;
      wcnt_q <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    sched_q <= sched_d;
    acc_q <= acc_d;
  end

endmodule

@@ src/sha1md_checker.sv @@
`include "sha1_message_digest_core_assert.svh"

module sha1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_final_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_number_i,
  input logic        out_done_i
);

  // digest beats and byte intake never overlap
  `SHA1MD_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, out_valid_i && in_ready_i)

  // a final beat starts padding or a compression, so intake stops at once
  `SHA1MD_ASSERT_NEXT(a_final_stalls, clk_i, rst_ni, in_valid_i && in_ready_i && in_final_i, !in_ready_i)

  // a digest starts with H0
  `SHA1MD_ASSERT_IMP(a_first_word, clk_i, rst_ni, $rose(out_valid_i), out_number_i == 3'd0)

  // done flag marks exactly the fifth word
  `SHA1MD_ASSERT_IMP(a_done_last, clk_i, rst_ni, out_valid_i, out_done_i == (out_number_i == 3'd4))

  // nothing more after the last word is taken
  `SHA1MD_ASSERT_NEXT(a_done_ends, clk_i, rst_ni, out_valid_i && out_ready_i && out_done_i, !out_valid_i)

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_final_i   (in_i.final_item),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_number_i (out_o.word_number),
  .out_done_i   (out_o.digest_done)
);

@@ dv/tb.sv @@
module tb;
  import sha1md_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned LongHold = 400;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        done;
  } digest_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sha1md_in_if  in_if ();
  sha1md_out_if out_if ();

  sha1_message_digest_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // running sha-1 state of the message in flight
  logic [31:0]  chain_h [NumChain];
  logic [31:0]  blk_w [16];
  int unsigned  blk_fill;
  logic [63:0]  msg_bits;

  digest_beat_t pending_digest_words [$];
  int unsigned  fail_count;
  int unsigned  beats_sent;
  int unsigned  stall_cycles;
  int unsigned  rx_hold_cycles;
  bit           gaps_on;

  function automatic logic [31:0] rot_left(logic [31:0] x, int unsigned n);
    logic [63:0] twice;
    twice = {x, x} << n;
    return twice[63:32];
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    for (int t = 0; t < 16; t++) w[t] = blk_w[t];
    for (int t = 16; t < 80; t++) begin
      w[t] = rot_left(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      tmp = rot_left(a, 5) + f + e + k + w[t];
      e = d;
      d = c;
      c = rot_left(b, 30);
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha1_absorb(logic [7:0] v);
    int unsigned idx, sh;
    idx = blk_fill >> 2;
    sh = (3 - (blk_fill & 3)) * 8;
    if ((blk_fill & 3) == 0) blk_w[idx] = {24'd0, v} << sh;
    else blk_w[idx] |= {24'd0, v} << sh;
    blk_fill++;
    if (blk_fill == 64) begin
      sha1_compress();
      blk_fill = 0;
    end
  endfunction

  function automatic void sha1_restart();
    for (int i = 0; i < NumChain; i++) chain_h[i] = HInit[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  // one accepted beat: absorb it, and on the final beat pad and queue the digest
  function automatic void sha1_take_item(logic [7:0] v, logic present, logic fin);
    logic [63:0]  len;
    digest_beat_t beat;
    if (present) begin
      sha1_absorb(v);
      msg_bits += 64'd8;
    end
    if (!fin) return;
    len = msg_bits;
    sha1_absorb(PadMarker);
    while (blk_fill != LenPos) sha1_absorb(8'h00);
    for (int i = 0; i < 8; i++) sha1_absorb(len[63 - 8*i -: 8]);
    for (int i = 0; i < NumChain; i++) begin
      beat.word = chain_h[i];
      beat.num  = 3'(i);
      beat.done = (3'(i) == LastWord);
      pending_digest_words = {pending_digest_words, beat};
    end
    sha1_restart();
  endfunction

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("%s", msg);
  endfunction

  // valid stays high between back-to-back beats, it only drops for a gap
  task automatic send_beat(input logic [7:0] byte_val, input logic present,
                           input logic fin);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= byte_val;
    in_if.byte_present <= present;
    in_if.final_item   <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sha1_take_item(byte_val, present, fin);
    if (present || fin) beats_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_message(input int unsigned len, input bit noisy);
    bit merge_last;
    merge_last = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      if (merge_last && i == len - 1) send_beat(pick_byte(), 1'b1, 1'b1);
      else send_beat(pick_byte(), 1'b1, 1'b0);
    end
    if (!merge_last) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // mostly short messages, with lengths around the padding and block edges
  function automatic int unsigned pick_message_length();
    int unsigned r;
    int unsigned edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 8);
    if (r < 60) return edges[$urandom_range(0, 7)];
    if (r < 85) return $urandom_range(9, 54);
    return $urandom_range(66, 140);
  endfunction

  task automatic test_directed_cases();
    // empty message
    send_beat(8'h5A, 1'b0, 1'b1);
    // "abc" with the last byte on the final beat
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    // idle beats mixed in, byte ignored when not present
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h3C, 1'b0, 1'b1);
    // single zero byte ending the message
    send_beat(8'h00, 1'b1, 1'b1);
    // idle beat on a fresh message, then empty message again
    send_beat(8'h81, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    // single 0xff byte
    send_beat(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_random_messages(input int unsigned target);
    while (beats_sent < target) send_message(pick_message_length(), 1'b1);
  endtask

  // receiver stalls while a new message keeps coming, input must back up
  task automatic test_digest_backpressure();
    rx_hold_cycles = LongHold;
    send_message(20, 1'b0);
    send_message(70, 1'b0);
  endtask

  task automatic test_pause_for_digest();
    send_message(pick_message_length(), 1'b1);
    in_if.valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk_i);
    send_message(3, 1'b0);
  endtask

  task automatic test_steady_stream(input int unsigned target);
    gaps_on = 1'b0;
    do send_message(pick_message_length(), 1'b0);
    while (beats_sent < target);
  endtask

  initial begin
    fail_count     = 0;
    beats_sent     = 0;
    rx_hold_cycles = 0;
    gaps_on        = 1'b1;
    for (int i = 0; i < 16; i++) blk_w[i] = '0;
    sha1_restart();
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= 8'h00;
    in_if.byte_present <= 1'b0;
    in_if.final_item   <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_messages(250);
    test_digest_backpressure();
    test_pause_for_digest();
    test_steady_stream(450);

    in_if.valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_digest_words.size() != 0) begin
      report_failure($sformatf("%0d digest beats never arrived",
                               pending_digest_words.size()));
    end
    if (fail_count == 0) begin
      $display("sha1_message_digest_core: match");
    end else begin
      $display("sha1_message_digest_core: mismatch");
    end
    $finish;
  end

  // digest receiver: random stall bursts while gaps_on is set, plus one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_digest
    digest_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_digest_words.size() == 0) begin
        report_failure($sformatf("unexpected digest beat: word %h num %0d done %b",
                                 out_if.digest_word, out_if.word_number,
                                 out_if.digest_done));
      end else begin
        want = pending_digest_words.pop_front();
        if (out_if.digest_word !== want.word || out_if.word_number !== want.num ||
            out_if.digest_done !== want.done) begin
          report_failure($sformatf(
            "digest beat differs: expected word %h num %0d done %b, got word %h num %0d done %b",
            want.word, want.num, want.done,
            out_if.digest_word, out_if.word_number, out_if.digest_done));
        end
      end
    end
  end

  // cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (rst_ni && stall_cycles >= StallLimit) begin
      $display("sha1_message_digest_core: mismatch");
      $finish;
    end
  end

endmodule
